@@ hdl/omps_pkg.sv @@
`timescale 1ns / 1ps

package omps_pkg;

    // Sequencer states of the search engine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_LAST,
        S_OUT
    } t_state;

    // Input word modes.
    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // Result word kinds.
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Largest value carried by a 16-bit result field.
    localparam logic [32:0] OUT16_MAX = 33'd65535;

    // Saturate a counter value of up to 33 bits into a 16-bit result field.
    function automatic logic [15:0] f_clip16(input logic [32:0] v);
        logic [15:0] r;
        if (v > OUT16_MAX) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/omps_ram.sv @@
`timescale 1ns / 1ps

module omps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/omps_cmp.sv @@
`timescale 1ns / 1ps

module omps_cmp (
    input  logic       i_clk,
    input  logic       i_clear,
    input  logic       i_valid,
    input  logic [7:0] i_text,
    input  logic [7:0] i_pat,
    output logic       o_within
);

    logic [1:0] r_diffs;
    logic [1:0] n_diffs;
    logic       w_miss;

    // One byte compare per cycle; the mismatch count saturates at two.
    always_comb begin
        w_miss  = i_valid && (i_text != i_pat);
        n_diffs = r_diffs;
        if (w_miss && (r_diffs != 2'd2)) begin
            n_diffs = r_diffs + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_diffs <= 2'd0;
        end else begin
            r_diffs <= n_diffs;
        end
    end

    // The window is a hit while at most one byte differs, current byte included.
    assign o_within = (n_diffs <= 2'd1);

endmodule

@@ hdl/one_mismatch_pattern_search.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Word
// input     in         i_valid / o_ready   i_mode, i_symbol, i_end_of_text
// result    out        o_valid / i_ready   o_kind, o_position, o_match_total,
//                                          o_pattern_overflow, o_final_res
// A pattern word goes to the pattern RAM, or sets the overflow flag once that is full.
// A text word is written to the buffer, then passes the shared byte comparator when a
// full window of pattern length L is held; each result word is held until it is taken.
// The comparator reads one pattern byte and one window byte per cycle from two RAMs.
// Reset is synchronous, active low, and clears all control state; the RAMs keep data.
// The block takes no input word until every result of the current word is taken.

module one_mismatch_pattern_search
    import omps_pkg::*;
#(
    parameter int PAT_MAX    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [7:0]  i_symbol,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [15:0] o_position,
    output logic [15:0] o_match_total,
    output logic        o_pattern_overflow,
    output logic        o_final_res
);

    localparam int AW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int LW = $clog2(PAT_MAX + 1);
    localparam int SW = LW + 1;
    localparam int CB = COUNT_BITS;

    t_state          r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic            r_ovf, n_ovf;
    logic            r_text, n_text;
    logic [AW-1:0]   r_head, n_head;
    logic [LW-1:0]   r_fill, n_fill;
    logic [CB-1:0]   r_seen, n_seen;
    logic [CB-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]   r_k, n_k;
    logic [AW-1:0]   r_taddr, n_taddr;
    logic            r_pend, n_pend;
    logic            r_eot, n_eot;
    logic            r_kind, n_kind;
    logic [15:0]     r_pos, n_pos;
    logic [15:0]     r_total, n_total;

    logic            w_pat_we;
    logic [AW-1:0]   w_pat_waddr;
    logic            w_txt_we;
    logic [7:0]      w_pat_rdata;
    logic [7:0]      w_txt_rdata;
    logic            w_clear;
    logic            w_within;
    logic [LW-1:0]   w_len_eff;
    logic [SW-1:0]   w_start;
    logic [CB:0]     w_pos_full;

    // Pattern and text window storage.
    omps_ram #(.WIDTH(8), .DEPTH(PAT_MAX), .AW(AW)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_pat_we),
        .i_waddr (w_pat_waddr),
        .i_wdata (i_symbol),
        .i_raddr (r_k),
        .o_rdata (w_pat_rdata)
    );

    omps_ram #(.WIDTH(8), .DEPTH(PAT_MAX), .AW(AW)) u_txt_ram (
        .i_clk   (i_clk),
        .i_we    (w_txt_we),
        .i_waddr (r_head),
        .i_wdata (i_symbol),
        .i_raddr (r_taddr),
        .o_rdata (w_txt_rdata)
    );

    // Shared byte comparator.
    omps_cmp u_cmp (
        .i_clk    (i_clk),
        .i_clear  (w_clear),
        .i_valid  (r_pend),
        .i_text   (w_txt_rdata),
        .i_pat    (w_pat_rdata),
        .o_within (w_within)
    );

    // Start of a match window, measured back from the newest text byte.
    assign w_pos_full = {1'b0, r_seen} - (CB + 1)'(r_len) + (CB + 1)'(1);

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_text  <= 1'b0;
            r_head  <= '0;
            r_fill  <= '0;
            r_seen  <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_text  <= n_text;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_seen  <= n_seen;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    // Payload registers of the sequencer and the result word.
    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_taddr <= n_taddr;
        r_eot   <= n_eot;
        r_kind  <= n_kind;
        r_pos   <= n_pos;
        r_total <= n_total;
    end

    // Next state and outputs of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_text      = r_text;
        n_head      = r_head;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_taddr     = r_taddr;
        n_pend      = 1'b0;
        n_eot       = r_eot;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_total     = r_total;
        w_pat_we    = 1'b0;
        w_pat_waddr = '0;
        w_txt_we    = 1'b0;
        w_clear     = 1'b0;
        w_len_eff   = r_len;
        w_start     = '0;
        o_ready     = 1'b0;
        o_valid     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && (i_mode == MODE_PATTERN)) begin
                    // A pattern word after text starts a new search from scratch.
                    if (r_text) begin
                        w_len_eff = '0;
                        n_text    = 1'b0;
                        n_ovf     = 1'b0;
                        n_seen    = '0;
                        n_cnt     = '0;
                        n_fill    = '0;
                    end
                    if (w_len_eff < LW'(PAT_MAX)) begin
                        w_pat_we    = 1'b1;
                        w_pat_waddr = w_len_eff[AW-1:0];
                        n_len       = w_len_eff + LW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (i_valid) begin
                    // Text word: push into the circular window and bump the counters.
                    w_txt_we = 1'b1;
                    n_text   = 1'b1;
                    n_eot    = i_end_of_text;
                    w_clear  = 1'b1;
                    if (SW'(r_head) == SW'(PAT_MAX - 1)) begin
                        n_head = '0;
                    end else begin
                        n_head = r_head + AW'(1);
                    end
                    if (r_fill != LW'(PAT_MAX)) begin
                        n_fill = r_fill + LW'(1);
                    end
                    if (r_seen != '1) begin
                        n_seen = r_seen + CB'(1);
                    end
                    w_start = SW'(n_head) + SW'(PAT_MAX) - SW'(r_len);
                    if (w_start >= SW'(PAT_MAX)) begin
                        w_start = w_start - SW'(PAT_MAX);
                    end
                    n_k     = '0;
                    n_taddr = w_start[AW-1:0];
                    if ((r_len != '0) && (n_fill >= r_len)) begin
                        n_state = S_CMP;
                    end else if (i_end_of_text) begin
                        n_kind  = KIND_SUMMARY;
                        n_pos   = '0;
                        n_total = f_clip16(33'(r_cnt));
                        n_state = S_OUT;
                    end
                end
            end

            S_CMP: begin
                // Issue one pattern and one window read per cycle.
                n_pend = 1'b1;
                n_k    = r_k + AW'(1);
                if (SW'(r_taddr) == SW'(PAT_MAX - 1)) begin
                    n_taddr = '0;
                end else begin
                    n_taddr = r_taddr + AW'(1);
                end
                if (LW'(r_k) == (r_len - LW'(1))) begin
                    n_state = S_LAST;
                end
            end

            S_LAST: begin
                // The last byte compare settles the verdict.
                if (w_within) begin
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + CB'(1);
                    end
                    n_kind  = KIND_MATCH;
                    n_pos   = f_clip16(33'(w_pos_full));
                    n_total = f_clip16(33'(n_cnt));
                    n_state = S_OUT;
                end else if (r_eot) begin
                    n_kind  = KIND_SUMMARY;
                    n_pos   = '0;
                    n_total = f_clip16(33'(r_cnt));
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_OUT: begin
                // Hold the result word; a summary may follow a match report.
                o_valid = 1'b1;
                if (i_ready) begin
                    if ((r_kind == KIND_MATCH) && r_eot) begin
                        n_kind  = KIND_SUMMARY;
                        n_pos   = '0;
                        n_total = f_clip16(33'(r_cnt));
                    end else if (r_kind == KIND_SUMMARY) begin
                        n_seen  = '0;
                        n_cnt   = '0;
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_kind             = r_kind;
    assign o_position         = r_pos;
    assign o_match_total      = r_total;
    assign o_pattern_overflow = r_ovf;
    assign o_final_res        = r_kind;

endmodule

@@ dv/one_mismatch_pattern_search_tb.sv @@
`timescale 1ns / 1ps

module one_mismatch_pattern_search_tb;
    import omps_pkg::*;

    localparam int PAT_DEPTH = 64;
    localparam int CNT_BITS  = 16;
    localparam logic [CNT_BITS-1:0] CNT_TOP = {CNT_BITS{1'b1}};
    localparam int RANDOM_WORDS = 450;

    // One input word as the sender offers it.
    typedef struct {
        logic       mode;
        logic [7:0] sym;
        logic       eot;
        bit         fast;
    } t_search_word;

    // One result word as the block should present it.
    typedef struct {
        logic        kind;
        logic [15:0] position;
        logic [15:0] total;
        logic        ovf;
        logic        fin;
    } t_search_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = MODE_PATTERN;
    logic [7:0]  i_symbol = 8'h00;
    logic        i_end_of_text = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_kind;
    logic [15:0] o_position;
    logic [15:0] o_match_total;
    logic        o_pattern_overflow;
    logic        o_final_res;

    one_mismatch_pattern_search #(
        .PAT_MAX    (PAT_DEPTH),
        .COUNT_BITS (CNT_BITS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_symbol           (i_symbol),
        .i_end_of_text      (i_end_of_text),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_position         (o_position),
        .o_match_total      (o_match_total),
        .o_pattern_overflow (o_pattern_overflow),
        .o_final_res        (o_final_res)
    );

    always #5ns i_clk = ~i_clk;

    t_search_word   search_words[$];
    t_search_report expected_reports[$];

    // Shadow copy of the search state.
    logic [7:0]          pat_mem[PAT_DEPTH];
    logic [7:0]          text_win[PAT_DEPTH];
    int                  pat_len = 0;
    int                  win_fill = 0;
    logic [CNT_BITS-1:0] text_cnt = '0;
    logic [CNT_BITS-1:0] hit_cnt = '0;
    logic                pat_ovf = 1'b0;
    logic                in_text = 1'b0;

    int  total_words = 0;
    int  words_taken = 0;
    int  reports_taken = 0;
    int  match_reports = 0;
    int  summaries = 0;
    int  mismatch_count = 0;
    bit  ovf_seen = 1'b0;
    bit  sat_seen = 1'b0;
    bit  fast_phase = 1'b0;
    int  tx_burst = 0;
    int  rx_burst = 0;

    // Work out the result words that one accepted input word causes.
    function automatic void predict_search(t_search_word w);
        int k;
        int diffs;
        t_search_report r;
        if (w.mode == MODE_PATTERN) begin
            // A pattern word after text starts a new search from scratch.
            if (in_text) begin
                pat_len  = 0;
                win_fill = 0;
                text_cnt = '0;
                hit_cnt  = '0;
                pat_ovf  = 1'b0;
                in_text  = 1'b0;
            end
            if (pat_len < PAT_DEPTH) begin
                pat_mem[pat_len] = w.sym;
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
            return;
        end
        in_text = 1'b1;
        for (k = 0; k < PAT_DEPTH - 1; k++) begin
            text_win[k] = text_win[k+1];
        end
        text_win[PAT_DEPTH-1] = w.sym;
        if (win_fill < PAT_DEPTH) win_fill++;
        if (text_cnt != CNT_TOP) text_cnt++;
        if (pat_len > 0 && win_fill >= pat_len) begin
            diffs = 0;
            for (k = 0; k < pat_len; k++) begin
                if (text_win[PAT_DEPTH - pat_len + k] != pat_mem[k]) diffs++;
            end
            if (diffs <= 1) begin
                if (hit_cnt != CNT_TOP) hit_cnt++;
                r.kind     = KIND_MATCH;
                r.position = 16'(text_cnt - CNT_BITS'(pat_len) + 1'b1);
                r.total    = 16'(hit_cnt);
                r.ovf      = pat_ovf;
                r.fin      = 1'b0;
                expected_reports.insert(expected_reports.size(), r);
            end
        end
        if (w.eot) begin
            r.kind     = KIND_SUMMARY;
            r.position = 16'd0;
            r.total    = 16'(hit_cnt);
            r.ovf      = pat_ovf;
            r.fin      = 1'b1;
            expected_reports.insert(expected_reports.size(), r);
            text_cnt = '0;
            hit_cnt  = '0;
            win_fill = 0;
        end
    endfunction

    // Mostly no gap, some short ones, a few long ones, and gap-free stretches.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 72) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_word(logic mode, logic [7:0] sym, logic eot, bit fast);
        t_search_word w;
        w.mode = mode;
        w.sym  = sym;
        w.eot  = eot;
        w.fast = fast;
        search_words.insert(search_words.size(), w);
    endfunction

    function automatic logic [7:0] pick_sym(bit narrow, logic [7:0] a0, logic [7:0] a1);
        if (narrow) return $urandom_range(0, 1) ? a0 : a1;
        return 8'($urandom_range(0, 255));
    endfunction

    // One pattern followed by one or more text runs. Text is built mostly from
    // copies of the pattern with up to two corrupted bytes so that matches are common.
    function automatic void add_search_case(int forced_len);
        int plen;
        int eff;
        int frags;
        int n;
        int k;
        int m;
        int more;
        bit narrow;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] pat[$];
        logic [7:0] txt[$];
        logic [7:0] frag[$];
        n = $urandom_range(0, 99);
        if (forced_len > 0) plen = forced_len;
        else if (n < 70) plen = $urandom_range(1, 6);
        else if (n < 92) plen = $urandom_range(7, 20);
        else plen = $urandom_range(60, 70);
        eff    = (plen > PAT_DEPTH) ? PAT_DEPTH : plen;
        narrow = $urandom_range(0, 1);
        a0     = 8'($urandom_range(0, 255));
        a1     = 8'($urandom_range(0, 255));
        for (k = 0; k < plen; k++) begin
            pat.insert(pat.size(), pick_sym(narrow, a0, a1));
            add_word(MODE_PATTERN, pat[k], 1'($urandom_range(0, 1)), 1'b0);
        end
        more = 1;
        while (more) begin
            txt.delete();
            frags = (eff > 20) ? $urandom_range(1, 2) : $urandom_range(1, 4);
            repeat (frags) begin
                frag.delete();
                if ($urandom_range(0, 9) < 6) begin
                    for (k = 0; k < eff; k++) frag.insert(frag.size(), pat[k]);
                    m = $urandom_range(0, 2);
                    repeat (m) begin
                        k = $urandom_range(0, eff - 1);
                        frag[k] = frag[k] ^ 8'($urandom_range(1, 255));
                    end
                end else begin
                    n = $urandom_range(1, (eff + 3 > 12) ? 12 : eff + 3);
                    repeat (n) frag.insert(frag.size(), pick_sym(narrow, a0, a1));
                end
                foreach (frag[j]) txt.insert(txt.size(), frag[j]);
            end
            // Now and then the text stops before a full window.
            if (eff > 1 && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(0, eff - 1);
                while (txt.size() > n) void'(txt.pop_back());
            end
            m = ($urandom_range(0, 99) < 85);
            foreach (txt[j]) begin
                add_word(MODE_TEXT, txt[j], (j == txt.size() - 1) ? 1'(m) : 1'b0, 1'b0);
            end
            more = m && ($urandom_range(0, 9) < 3);
        end
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            // Cap the log so that a badly broken block does not flood it.
            if (mismatch_count <= 50) begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // Input driver: offers queued words, with random gaps between them.
    t_search_word cur_word;
    int           tx_gap = 0;

    always @(posedge i_clk) begin
        t_search_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_search(cur_word);
                words_taken++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0 || search_words.size() == 0) begin
                    i_valid <= 1'b0;
                    if (tx_gap > 0) tx_gap--;
                end else begin
                    w = search_words.pop_front();
                    cur_word = w;
                    i_mode        <= w.mode;
                    i_symbol      <= w.sym;
                    i_end_of_text <= w.eot;
                    i_valid       <= 1'b1;
                    fast_phase    <= w.fast;
                    tx_gap = w.fast ? 0 : pick_gap(tx_burst);
                end
            end
        end
    end

    // Result monitor and receiver stalls, with one long hold-off to back up the block.
    int rx_hold = 0;
    bit pressure_done = 1'b0;

    always @(posedge i_clk) begin
        t_search_report e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                reports_taken++;
                if (o_kind == KIND_SUMMARY) summaries++;
                else match_reports++;
                if (o_pattern_overflow) ovf_seen = 1'b1;
                if (o_match_total == 16'hFFFF) sat_seen = 1'b1;
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    $error("result word with nothing expected: kind %0d position %0d",
                           o_kind, o_position);
                end else begin
                    e = expected_reports.pop_front();
                    check_field("kind", e.kind, o_kind);
                    check_field("position", e.position, o_position);
                    check_field("match_total", e.total, o_match_total);
                    check_field("pattern_overflow", e.ovf, o_pattern_overflow);
                    check_field("final_res", e.fin, o_final_res);
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else if (!pressure_done && reports_taken >= 30 && search_words.size() > 0) begin
                pressure_done = 1'b1;
                rx_hold = 400;
                i_ready <= 1'b0;
            end else if (fast_phase) begin
                i_ready <= 1'b1;
            end else begin
                rx_hold = pick_gap(rx_burst);
                i_ready <= (rx_hold == 0);
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Text with no pattern loaded yet.
        add_word(MODE_TEXT, 8'h00, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'hFF, 1'b1, 1'b0);
        // Two-byte pattern; end of text is ignored on pattern words.
        add_word(MODE_PATTERN, 8'hFF, 1'b1, 1'b0);
        add_word(MODE_PATTERN, 8'h00, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h00, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h00, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h55, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'hAA, 1'b1, 1'b0);
        // New text that ends before a full window.
        add_word(MODE_TEXT, 8'hFF, 1'b1, 1'b0);
        // Single-byte pattern; a match and a summary from the same word.
        add_word(MODE_PATTERN, 8'h80, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h7F, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h80, 1'b1, 1'b0);
        // Three-byte pattern with exact, three-off and two-off windows.
        add_word(MODE_PATTERN, 8'h01, 1'b0, 1'b0);
        add_word(MODE_PATTERN, 8'h02, 1'b0, 1'b0);
        add_word(MODE_PATTERN, 8'h03, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h01, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h02, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h03, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h09, 1'b0, 1'b0);
        add_word(MODE_TEXT, 8'h03, 1'b1, 1'b0);

        // A pattern longer than the store, then random searches.
        add_search_case(PAT_DEPTH + 2);
        while (search_words.size() < 21 + RANDOM_WORDS) add_search_case(0);
        total_words = search_words.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken != total_words || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);

        $display("Searched %0d input words: %0d match reports and %0d end summaries checked.",
                 total_words, match_reports, summaries);
        $display("Pattern overflow seen: %0d, saturated match total seen: %0d.",
                 ovf_seen, sat_seen);
        if (mismatch_count == 0) begin
            $display("one_mismatch_pattern_search: match");
        end else begin
            $display("one_mismatch_pattern_search: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #30_000_000;
        $display("one_mismatch_pattern_search: mismatch");
        $finish;
    end

endmodule
